FILE: hdl/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolation unit.
// Used by every module in hdl; depends on nothing.
package plti_pkg;

  localparam int POINTS = 8;
  localparam int DW     = 24;
  localparam int IDXW   = 3;
  localparam int CNTW   = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Selected segment, registered after the table search.
  typedef struct packed {
    logic          valid;
    logic          direct;
    logic [DW-1:0] ya;
    logic [DW-1:0] yb;
    logic [DW-1:0] xa;
    logic [DW-1:0] xb;
    logic [DW-1:0] v;
  } sel_t;

  // One stage of the restoring divider with its side payload.
  typedef struct packed {
    logic          valid;
    logic          direct;
    logic          err;
    logic          neg;
    logic [DW-1:0] ya;
    logic [DW-1:0] dx;
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
    logic [DW-1:0] quo;
  } div_t;

endpackage

FILE: hdl/plti_select.sv
// Breakpoint table storage and segment search for the interpolation unit.
// Depends on plti_pkg.
module plti_select (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        accept,
  input  plti_pkg::op_t               op,
  input  logic [plti_pkg::IDXW-1:0]   point_index,
  input  logic [plti_pkg::DW-1:0]     point_speed,
  input  logic [plti_pkg::DW-1:0]     point_torque,
  input  logic [plti_pkg::DW-1:0]     query_speed,
  input  logic [plti_pkg::CNTW-1:0]   points_in_use,
  output plti_pkg::sel_t              sel
);

  logic [plti_pkg::DW-1:0]     speed_table  [plti_pkg::POINTS];
  logic [plti_pkg::DW-1:0]     torque_table [plti_pkg::POINTS];
  logic [plti_pkg::CNTW-1:0]   n_act;
  logic [plti_pkg::IDXW-1:0]   last;
  logic [plti_pkg::POINTS-1:0] gt;
  logic [plti_pkg::POINTS-2:0] lane;
  plti_pkg::sel_t              sel_next;

  always_ff @(posedge clk) begin
    if (accept && op == plti_pkg::OP_LOAD) begin
      speed_table[point_index]  <= point_speed;
      torque_table[point_index] <= point_torque;
    end
  end

  always_comb begin
    if (points_in_use == '0) begin
      n_act = plti_pkg::CNTW'(1);
    end else if (points_in_use > plti_pkg::CNTW'(plti_pkg::POINTS)) begin
      n_act = plti_pkg::CNTW'(plti_pkg::POINTS);
    end else begin
      n_act = points_in_use;
    end
    last = plti_pkg::IDXW'(n_act - plti_pkg::CNTW'(1));
  end

  // Each lane owns one segment; the first breakpoint above the query closes it.
  always_comb begin
    logic still;
    still = 1'b1;
    for (int j = 0; j < plti_pkg::POINTS; j++) begin
      gt[j] = speed_table[j] > query_speed;
    end
    for (int k = 0; k < plti_pkg::POINTS - 1; k++) begin
      if (k > 0) begin
        still = still & ~gt[k];
      end
      lane[k] = still && (k < int'(n_act) - 1) &&
                ((k == int'(n_act) - 2) || gt[k + 1]);
    end
  end

  always_comb begin
    sel_next        = '0;
    sel_next.valid  = accept && op == plti_pkg::OP_QUERY;
    sel_next.v      = query_speed;
    if (query_speed <= speed_table[0]) begin
      sel_next.direct = 1'b1;
      sel_next.ya     = torque_table[0];
    end else if (query_speed >= speed_table[last]) begin
      sel_next.direct = 1'b1;
      sel_next.ya     = torque_table[last];
    end else begin
      for (int k = 0; k < plti_pkg::POINTS - 1; k++) begin
        if (lane[k]) begin
          sel_next.ya = sel_next.ya | torque_table[k];
          sel_next.yb = sel_next.yb | torque_table[k + 1];
          sel_next.xa = sel_next.xa | speed_table[k];
          sel_next.xb = sel_next.xb | speed_table[k + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel.valid <= 1'b0;
    end else if (adv) begin
      sel <= sel_next;
    end
  end

endmodule

FILE: hdl/plti_divstep.sv
// One registered step of the restoring divider, one quotient bit per stage.
// Depends on plti_pkg.
module plti_divstep (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  plti_pkg::div_t d_in,
  output plti_pkg::div_t d_out
);

  logic [plti_pkg::DW:0] trial;
  logic [plti_pkg::DW:0] diff;
  plti_pkg::div_t        d_next;

  always_comb begin
    trial  = {d_in.rem, d_in.num[plti_pkg::DW-1]};
    diff   = trial - {1'b0, d_in.dx};
    d_next = d_in;
    d_next.num = {d_in.num[plti_pkg::DW-2:0], 1'b0};
    if (!diff[plti_pkg::DW]) begin
      d_next.rem = diff[plti_pkg::DW-1:0];
      d_next.quo = {d_in.quo[plti_pkg::DW-2:0], 1'b1};
    end else begin
      d_next.rem = trial[plti_pkg::DW-1:0];
      d_next.quo = {d_in.quo[plti_pkg::DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (adv) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: hdl/piecewise_linear_table_interp_unit.sv
// Piecewise-linear speed-to-torque lookup over a breakpoint table.
// An accepted query word passes to its result word through one
// search stage, one difference stage, one multiply stage, 24 divider stages
// (one quotient bit each) and the output register. Throughput is one word per
// cycle; the whole pipeline moves only when the output register can advance.
// Synchronous active-high rst clears all valid bits and sets points_in_use to 1.
module piecewise_linear_table_interp_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,      // points_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  // point_index[2:0], point_speed[26:3], point_torque[50:27],
  // query_speed[74:51], zero fill[79:75]
  input  logic [79:0] s_tdata,
  input  logic        s_tuser,        // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,        // torque
  output logic        m_tuser         // table_error
);

  localparam int DW = plti_pkg::DW;

  logic [plti_pkg::CNTW-1:0] points_in_use;
  logic                      adv;
  logic                      accept;
  plti_pkg::op_t             op;
  plti_pkg::sel_t            sel;

  // Stage 2: spans and offsets.
  logic          s2_valid;
  logic          s2_direct;
  logic          s2_err;
  logic          s2_neg;
  logic [DW-1:0] s2_ya;
  logic [DW-1:0] s2_dx;
  logic [DW-1:0] s2_dv;
  logic [DW-1:0] s2_mag;

  logic [DW:0]   dx_full;
  logic [DW:0]   dy_full;

  // Stage 3 feeds the divider chain.
  plti_pkg::div_t          div_chain [DW+1];
  logic [2*DW-1:0]         prod;

  logic [DW+1:0]           q_s;
  logic [DW+1:0]           sum;
  logic [DW-1:0]           res;

  // The pipeline advances as one; the output register decides.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;
  assign op       = plti_pkg::op_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= plti_pkg::CNTW'(1);
    end else if (cfg_we) begin
      points_in_use <= cfg_wdata;
    end
  end

  plti_select u_select (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .accept       (accept),
    .op           (op),
    .point_index  (s_tdata[2:0]),
    .point_speed  (s_tdata[26:3]),
    .point_torque (s_tdata[50:27]),
    .query_speed  (s_tdata[74:51]),
    .points_in_use(points_in_use),
    .sel          (sel)
  );

  // A non-positive span on an interpolated segment reports an error.
  assign dx_full = {1'b0, sel.xb} - {1'b0, sel.xa};
  assign dy_full = {sel.yb[DW-1], sel.yb} - {sel.ya[DW-1], sel.ya};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= sel.valid;
      s2_direct <= sel.direct;
      s2_err    <= !sel.direct && (dx_full[DW] || dx_full == '0);
      s2_neg    <= dy_full[DW];
      s2_ya     <= sel.ya;
      s2_dx     <= dx_full[DW-1:0];
      s2_dv     <= sel.v - sel.xa;
      s2_mag    <= dy_full[DW] ? DW'(-dy_full) : dy_full[DW-1:0];
    end
  end

  // The offset times the torque magnitude; the span bounds the quotient to DW bits.
  assign prod = s2_dv * s2_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_chain[0].valid <= 1'b0;
    end else if (adv) begin
      div_chain[0].valid  <= s2_valid;
      div_chain[0].direct <= s2_direct;
      div_chain[0].err    <= s2_err;
      div_chain[0].neg    <= s2_neg;
      div_chain[0].ya     <= s2_ya;
      div_chain[0].dx     <= s2_dx;
      div_chain[0].rem    <= prod[2*DW-1:DW];
      div_chain[0].num    <= prod[DW-1:0];
      div_chain[0].quo    <= '0;
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_div
    plti_divstep u_step (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .d_in (div_chain[g]),
      .d_out(div_chain[g + 1])
    );
  end

  // Quotient magnitude with its sign restored truncates toward zero.
  always_comb begin
    q_s = div_chain[DW].neg ? -{2'b00, div_chain[DW].quo} : {2'b00, div_chain[DW].quo};
    sum = {{2{div_chain[DW].ya[DW-1]}}, div_chain[DW].ya} + q_s;
    if (!sum[DW+1] && (sum[DW] || sum[DW-1])) begin
      res = {1'b0, {(DW-1){1'b1}}};
    end else if (sum[DW+1] && !(sum[DW] && sum[DW-1])) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= div_chain[DW].valid;
      m_tuser  <= div_chain[DW].err;
      if (div_chain[DW].direct) begin
        m_tdata <= div_chain[DW].ya;
      end else if (div_chain[DW].err) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // An erroneous segment always yields a zero torque.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error word with nonzero torque");

  // A clamped result never carries the error flag in the chain.
  a_direct_noerr: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_direct |-> !s2_err)
    else $error("direct result flagged as error");

  // Nothing leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

FILE: verif/piecewise_linear_table_interp_unit_test.sv
// Self-checking testbench for the piecewise-linear speed-to-torque lookup unit.
// Depends on hdl/plti_pkg.sv and hdl/piecewise_linear_table_interp_unit.sv.
module piecewise_linear_table_interp_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Torque expected for one query word, in the order queries were accepted.
  typedef struct {
    logic [23:0] torque;
    logic        table_error;
  } torque_word_t;

  // Keeps a private copy of the breakpoint table and the point count, predicts
  // the torque of every accepted query and compares it with what comes out.
  class torque_scoreboard;
    logic [23:0]  speed_pts [plti_pkg::POINTS];
    logic [23:0]  torque_pts [plti_pkg::POINTS];
    logic [3:0]   point_count;
    torque_word_t pending_torque[$];
    int           errors;

    function void reset_state();
      point_count = 4'd1;
      pending_torque.delete();
      errors = 0;
      foreach (speed_pts[i]) begin
        speed_pts[i] = '0;
        torque_pts[i] = '0;
      end
    endfunction

    function void note_input(plti_pkg::op_t op, logic [2:0] idx, logic [23:0] ps,
                             logic [23:0] pt, logic [23:0] qs);
      int unsigned  n;
      int unsigned  i;
      longint       v, xa, xb, ya, yb, dx, res;
      torque_word_t w;
      if (op == plti_pkg::OP_LOAD) begin
        speed_pts[idx] = ps;
        torque_pts[idx] = pt;
        return;
      end
      // A count of zero behaves as one, anything above the table size as full.
      n = (point_count == 0) ? 1 : (point_count > plti_pkg::POINTS) ?
          plti_pkg::POINTS : 32'(point_count);
      v = longint'(qs);
      w.table_error = 1'b0;
      if (v <= longint'(speed_pts[0])) begin
        res = longint'($signed(torque_pts[0]));
      end else if (v >= longint'(speed_pts[n-1])) begin
        res = longint'($signed(torque_pts[n-1]));
      end else begin
        i = 0;
        while (i + 1 < n - 1 && longint'(speed_pts[i+1]) <= v) i++;
        xa = longint'(speed_pts[i]);
        xb = longint'(speed_pts[i+1]);
        ya = longint'($signed(torque_pts[i]));
        yb = longint'($signed(torque_pts[i+1]));
        dx = xb - xa;
        if (dx <= 0) begin
          // Guard for a segment with no positive speed span.
          res = 0;
          w.table_error = 1'b1;
        end else begin
          res = ya + ((v - xa) * (yb - ya)) / dx;
          if (res > 8388607) res = 8388607;
          if (res < -8388608) res = -8388608;
        end
      end
      w.torque = res[23:0];
      pending_torque.push_back(w);
    endfunction

    function void check_result(logic [23:0] torque, logic table_error);
      torque_word_t w;
      if (pending_torque.size() == 0) begin
        $display("%0t: unexpected result word torque=%h error=%b",
                 $realtime, torque, table_error);
        errors++;
        return;
      end
      w = pending_torque.pop_front();
      if (torque !== w.torque) begin
        $display("%0t: torque mismatch expected %h actual %h",
                 $realtime, w.torque, torque);
        errors++;
      end
      if (table_error !== w.table_error) begin
        $display("%0t: table_error mismatch expected %b actual %b",
                 $realtime, w.table_error, table_error);
        errors++;
      end
    endfunction
  endclass

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // point_index, point_speed, point_torque, query_speed
  logic        s_tuser;   // op
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // torque
  logic        m_tuser;   // table_error

  torque_scoreboard sb;
  bit               calm;     // when set, neither side idles
  int               cycles;
  logic [23:0]      phase_speed [plti_pkg::POINTS];

  piecewise_linear_table_interp_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stalls about a fifth of the time unless a calm stretch is running.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 20);
  end

  // Every result word is checked at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Offers one word and holds it until it is taken. Gaps are inserted by
  // dropping tvalid first, so tvalid is never lowered and raised within one
  // time step.
  task automatic send_word(plti_pkg::op_t op, logic [2:0] idx, logic [23:0] ps,
                           logic [23:0] pt, logic [23:0] qs);
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, qs, pt, ps, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, idx, ps, pt, qs);
  endtask

  task automatic load_point(int idx, logic [23:0] ps, logic [23:0] pt);
    send_word(plti_pkg::OP_LOAD, idx[2:0], ps, pt, 24'($urandom()));
  endtask

  task automatic query(logic [23:0] qs);
    send_word(plti_pkg::OP_QUERY, 3'($urandom()), 24'($urandom()), 24'($urandom()), qs);
  endtask

  // Sender pauses until every result has come, lets trailing loads leave the
  // pipeline, and only then changes the point count.
  task automatic set_points(logic [3:0] count);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_torque.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.point_count = count;
  endtask

  // Loads all eight slots, usually in rising speed order.
  task automatic load_table(bit sorted, int unsigned max_step, bit small_torque);
    logic [23:0] x;
    logic [23:0] y;
    x = 24'($urandom_range(max_step));
    for (int i = 0; i < plti_pkg::POINTS; i++) begin
      y = small_torque ? 24'($signed($urandom_range(2000)) - 1000) : 24'($urandom());
      if (!sorted) x = 24'($urandom());
      phase_speed[i] = x;
      load_point(i, x, y);
      x = x + 24'($urandom_range(max_step, 1));
    end
  endtask

  initial begin
    logic [3:0]  count;
    int unsigned lo, hi;
    sb        = new();
    sb.reset_state();
    calm      = 1'b0;
    cycles    = 0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = plti_pkg::OP_LOAD;
    m_tready  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Every slot is written before the first query so no
    // unwritten entry is ever read. Torque extremes sit on adjacent points.
    load_point(0, 24'd100, 24'h800000);
    load_point(1, 24'd1100, 24'h7FFFFF);
    load_point(2, 24'd2100, 24'h000000);
    load_point(3, 24'd2101, 24'hFFFF00);
    load_point(4, 24'd50000, 24'h001234);
    load_point(5, 24'd60000, 24'hFFFFFF);
    load_point(6, 24'd60001, 24'h000100);
    load_point(7, 24'hFFFFFE, 24'h7FFFFF);
    // Reset count of one: every query clamps to the first torque.
    query(24'd0);
    query(24'd5000);
    query(24'hFFFFFF);
    set_points(4'd8);
    query(24'd0);          // below the first breakpoint
    query(24'd100);        // exactly on the first breakpoint
    query(24'd600);        // steep rising segment
    query(24'd1100);       // on an inner breakpoint
    query(24'd2000);
    query(24'd2100);
    query(24'd30000);
    query(24'd60000);
    query(24'hFFFFFD);     // just short of the last breakpoint
    query(24'hFFFFFF);     // above the last breakpoint

    // Random phases: a new point count (first the out-of-range ones), a new
    // table, then mostly queries inside its speed span with some reloads.
    for (int phase = 0; phase < 12; phase++) begin
      count = (phase == 0) ? 4'd0 : (phase == 1) ? 4'd15 :
              (phase == 2) ? 4'd1 : (phase == 3) ? 4'd8 : 4'($urandom_range(15));
      set_points(count);
      calm = (phase == 5);
      load_table($urandom_range(9) != 0,
                 ($urandom_range(1) != 0) ? 255 : 2000000, $urandom_range(1) != 0);
      for (int k = 0; k < 130; k++) begin
        if ($urandom_range(99) < 12) begin
          load_point(int'($urandom_range(plti_pkg::POINTS - 1)), 24'($urandom()),
                     24'($urandom()));
        end else if ($urandom_range(99) < 30) begin
          query(24'($urandom()));
        end else begin
          lo = 32'(phase_speed[0]);
          hi = 32'(phase_speed[plti_pkg::POINTS - 1]);
          if (lo > hi) begin
            lo = 32'(phase_speed[plti_pkg::POINTS - 1]);
            hi = 32'(phase_speed[0]);
          end
          query(24'($urandom_range(hi, lo)));
        end
      end
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_torque.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
